FILE: rtl/c8ic_pkg.sv
// Shared types and constants for the CHIP-8 instruction core.
// Holds request codes, decoded instruction classes and the font table.
// Depends on nothing.
package c8ic_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int FONT_BYTES  = 80;

    localparam logic [11:0] PC_RESET = 12'h200;
    localparam logic [15:0] OP_CLS   = 16'h00E0;
    localparam logic [15:0] OP_RET   = 16'h00EE;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_EXEC  = 2'd1,
        REQ_PIXEL = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        CL_CLS,
        CL_RET,
        CL_JP,
        CL_CALL,
        CL_SE_IMM,
        CL_SNE_IMM,
        CL_SE_REG,
        CL_SNE_REG,
        CL_LD,
        CL_ADD,
        CL_LDI,
        CL_DRW,
        CL_BAD
    } op_class_t;

    typedef struct packed {
        op_class_t   cls;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  n;
        logic [7:0]  nn;
        logic [11:0] nnn;
    } dec_t;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

FILE: rtl/c8ic_decode.sv
// Instruction decoder for the CHIP-8 instruction core.
// Splits a fetched word into its class and operand fields.
// Depends on c8ic_pkg.
module c8ic_decode
(
    input  logic [15:0]    op,
    output c8ic_pkg::dec_t dec
);

    always_comb
    begin
        dec.x   = op[11:8];
        dec.y   = op[7:4];
        dec.n   = op[3:0];
        dec.nn  = op[7:0];
        dec.nnn = op[11:0];
        case (op[15:12])
            4'h0:
            begin
                if (op == c8ic_pkg::OP_CLS)
                    dec.cls = c8ic_pkg::CL_CLS;
                else if (op == c8ic_pkg::OP_RET)
                    dec.cls = c8ic_pkg::CL_RET;
                else
                    dec.cls = c8ic_pkg::CL_BAD;
            end
            4'h1:    dec.cls = c8ic_pkg::CL_JP;
            4'h2:    dec.cls = c8ic_pkg::CL_CALL;
            4'h3:    dec.cls = c8ic_pkg::CL_SE_IMM;
            4'h4:    dec.cls = c8ic_pkg::CL_SNE_IMM;
            4'h5:    dec.cls = c8ic_pkg::CL_SE_REG;
            4'h6:    dec.cls = c8ic_pkg::CL_LD;
            4'h7:    dec.cls = c8ic_pkg::CL_ADD;
            4'h9:    dec.cls = c8ic_pkg::CL_SNE_REG;
            4'hA:    dec.cls = c8ic_pkg::CL_LDI;
            4'hD:    dec.cls = c8ic_pkg::CL_DRW;
            default: dec.cls = c8ic_pkg::CL_BAD;
        endcase
    end

endmodule

FILE: rtl/chip8_instruction_core.sv
// Top level of the CHIP-8 instruction core: sequencer, memories and registers.
// Uses c8ic_pkg and c8ic_decode.
//
// Channel  Dir  Handshake          Payload
// s_*      in   tvalid/tready      tuser req_type, tdata addr and data
// m_*      out  tvalid/tready      tdata result word
//
// Writes use S_WR, in-range pixel reads S_PR and S_PQ; other non-execute words go to S_DONE.
// An instruction passes S_F1, S_F2, S_RDX, S_RDY and S_EXE; a clear screen then clears one pixel per cycle.
// A draw of N rows wraps the origin in S_MX and S_MY, then reads and writes eight pixels per row.
// After reset S_INIT writes the font and zeros to memory and clears the screen.
// A word is accepted only when the block is idle and the result register is empty.
module chip8_instruction_core
#(
    parameter int FRAME_WIDTH  = 64,
    parameter int FRAME_HEIGHT = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // addr[11:0], data[19:12], zero pad
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // pc_after, fetched_opcode, pixel_value, flag_reg,
                                  // unimplemented, zero pad
);

    localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int FB_AW = $clog2(FRAME_PIXELS);
    localparam int CLR_N = (c8ic_pkg::MEM_BYTES > FRAME_PIXELS) ?
                           c8ic_pkg::MEM_BYTES : FRAME_PIXELS;
    localparam int CNT_W = $clog2(CLR_N);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_WR, S_PR, S_PQ, S_F1, S_F2, S_RDX, S_RDY, S_EXE,
        S_CLS, S_MX, S_MY, S_ROW, S_LINE, S_PRD, S_PWR, S_DONE
    } state_t;

    state_t state_reg;

    logic [7:0]       mem_ram [c8ic_pkg::MEM_BYTES];
    logic             frame_ram [FRAME_PIXELS];
    logic [7:0]       mem_q;
    logic             frame_q;

    logic [7:0]       gp_reg [16];
    logic [11:0]      stack_reg [c8ic_pkg::STACK_DEPTH];
    logic [11:0]      pc_reg;
    logic [11:0]      i_reg;
    logic [3:0]       sp_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [11:0]      addr_reg;
    logic [7:0]       data_reg;
    logic [15:0]      op_reg;
    logic             pix_reg;
    logic             unimpl_reg;
    logic [7:0]       vx_reg;
    logic [7:0]       vy_reg;
    logic [7:0]       px_base_reg;
    logic [7:0]       px_reg;
    logic [7:0]       py_reg;
    logic [3:0]       row_reg;
    logic [2:0]       col_reg;
    logic [7:0]       line_reg;
    logic             hit_reg;
    logic             m_tvalid_reg;

    c8ic_pkg::dec_t   dec;
    logic [11:0]      pc_next;
    logic [11:0]      pc_skip;
    logic [11:0]      pc_exe;
    logic [3:0]       sp_dec;
    logic [FB_AW-1:0] pix_idx;

    logic [11:0]      mem_ra;
    logic             mem_we;
    logic [11:0]      mem_wa;
    logic [7:0]       mem_wd;
    logic [FB_AW-1:0] fb_ra;
    logic             fb_we;
    logic [FB_AW-1:0] fb_wa;
    logic             fb_wd;

    c8ic_decode u_decode
    (
        .op  (op_reg),
        .dec (dec)
    );

    assign pc_next  = pc_reg + 12'd2;
    assign pc_skip  = pc_reg + 12'd4;
    assign sp_dec   = sp_reg - 4'd1;
    assign pix_idx  = FB_AW'(int'(py_reg) * FRAME_WIDTH + int'(px_reg));
    assign s_tready = (state_reg == S_IDLE) && !m_tvalid_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, unimpl_reg, gp_reg[15], pix_reg, op_reg, pc_reg};

    always_comb
    begin
        case (dec.cls)
            c8ic_pkg::CL_RET:                   pc_exe = stack_reg[sp_dec] + 12'd2;
            c8ic_pkg::CL_JP, c8ic_pkg::CL_CALL: pc_exe = dec.nnn;
            c8ic_pkg::CL_SE_IMM:  pc_exe = (vx_reg == dec.nn) ? pc_skip : pc_next;
            c8ic_pkg::CL_SNE_IMM: pc_exe = (vx_reg != dec.nn) ? pc_skip : pc_next;
            c8ic_pkg::CL_SE_REG:  pc_exe = (vx_reg == vy_reg) ? pc_skip : pc_next;
            c8ic_pkg::CL_SNE_REG: pc_exe = (vx_reg != vy_reg) ? pc_skip : pc_next;
            default:              pc_exe = pc_next;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_F1:    mem_ra = pc_reg + 12'd1;
            S_ROW:   mem_ra = i_reg + 12'(row_reg);
            default: mem_ra = pc_reg;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = data_reg;
        fb_we  = 1'b0;
        fb_wa  = pix_idx;
        fb_wd  = frame_q ^ line_reg[7];
        fb_ra  = pix_idx;
        case (state_reg)
            S_INIT:
            begin
                mem_we = int'(cnt_reg) < c8ic_pkg::MEM_BYTES;
                mem_wa = cnt_reg[11:0];
                mem_wd = (int'(cnt_reg) < c8ic_pkg::FONT_BYTES) ?
                         c8ic_pkg::FONT_ROM[cnt_reg[6:0]] : 8'd0;
                fb_we  = int'(cnt_reg) < FRAME_PIXELS;
                fb_wa  = FB_AW'(cnt_reg);
                fb_wd  = 1'b0;
            end
            S_CLS:
            begin
                fb_we = 1'b1;
                fb_wa = FB_AW'(cnt_reg);
                fb_wd = 1'b0;
            end
            S_WR:    mem_we = 1'b1;
            S_PR:    fb_ra  = FB_AW'(addr_reg);
            S_PWR:   fb_we  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem_ram[mem_wa] <= mem_wd;
        mem_q <= mem_ram[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
            frame_ram[fb_wa] <= fb_wd;
        frame_q <= frame_ram[fb_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            pc_reg       <= c8ic_pkg::PC_RESET;
            i_reg        <= 12'd0;
            sp_reg       <= 4'd0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            op_reg       <= 16'd0;
            pix_reg      <= 1'b0;
            unimpl_reg   <= 1'b0;
            for (int k = 0; k < 16; k++)
                gp_reg[k] <= 8'd0;
            for (int k = 0; k < c8ic_pkg::STACK_DEPTH; k++)
                stack_reg[k] <= 12'd0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    if (cnt_reg == CNT_W'(CLR_N - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        addr_reg   <= s_tdata[11:0];
                        data_reg   <= s_tdata[19:12];
                        op_reg     <= 16'd0;
                        pix_reg    <= 1'b0;
                        unimpl_reg <= 1'b0;
                        case (c8ic_pkg::req_t'(s_tuser))
                            c8ic_pkg::REQ_WRITE: state_reg <= S_WR;
                            c8ic_pkg::REQ_EXEC:  state_reg <= S_F1;
                            c8ic_pkg::REQ_PIXEL:
                            begin
                                if (int'(s_tdata[11:0]) < FRAME_PIXELS)
                                    state_reg <= S_PR;
                                else
                                    state_reg <= S_DONE;
                            end
                            default:             state_reg <= S_DONE;
                        endcase
                    end
                end
                S_WR:  state_reg <= S_DONE;
                S_PR:  state_reg <= S_PQ;
                S_PQ:
                begin
                    pix_reg   <= frame_q;
                    state_reg <= S_DONE;
                end
                S_F1:
                begin
                    op_reg[15:8] <= mem_q;
                    state_reg    <= S_F2;
                end
                S_F2:
                begin
                    op_reg[7:0] <= mem_q;
                    state_reg   <= S_RDX;
                end
                S_RDX:
                begin
                    vx_reg    <= gp_reg[dec.x];
                    state_reg <= S_RDY;
                end
                S_RDY:
                begin
                    vy_reg    <= gp_reg[dec.y];
                    state_reg <= S_EXE;
                end
                S_EXE:
                begin
                    pc_reg <= pc_exe;
                    case (dec.cls)
                        c8ic_pkg::CL_CLS:
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_CLS;
                        end
                        c8ic_pkg::CL_RET:
                        begin
                            sp_reg    <= sp_dec;
                            state_reg <= S_DONE;
                        end
                        c8ic_pkg::CL_CALL:
                        begin
                            stack_reg[sp_reg] <= pc_reg;
                            sp_reg            <= sp_reg + 4'd1;
                            state_reg         <= S_DONE;
                        end
                        c8ic_pkg::CL_JP, c8ic_pkg::CL_SE_IMM, c8ic_pkg::CL_SNE_IMM,
                        c8ic_pkg::CL_SE_REG, c8ic_pkg::CL_SNE_REG:
                            state_reg <= S_DONE;
                        c8ic_pkg::CL_LD:
                        begin
                            gp_reg[dec.x] <= dec.nn;
                            state_reg     <= S_DONE;
                        end
                        c8ic_pkg::CL_ADD:
                        begin
                            gp_reg[dec.x] <= vx_reg + dec.nn;
                            state_reg     <= S_DONE;
                        end
                        c8ic_pkg::CL_LDI:
                        begin
                            i_reg     <= dec.nnn;
                            state_reg <= S_DONE;
                        end
                        c8ic_pkg::CL_DRW:
                        begin
                            px_base_reg <= vx_reg;
                            py_reg      <= vy_reg;
                            row_reg     <= 4'd0;
                            hit_reg     <= 1'b0;
                            state_reg   <= S_MX;
                        end
                        default:
                        begin
                            unimpl_reg <= 1'b1;
                            state_reg  <= S_DONE;
                        end
                    endcase
                end
                S_CLS:
                begin
                    if (cnt_reg == CNT_W'(FRAME_PIXELS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_MX:
                begin
                    if (px_base_reg >= 8'(FRAME_WIDTH))
                        px_base_reg <= px_base_reg - 8'(FRAME_WIDTH);
                    else
                        state_reg <= S_MY;
                end
                S_MY:
                begin
                    if (py_reg >= 8'(FRAME_HEIGHT))
                        py_reg <= py_reg - 8'(FRAME_HEIGHT);
                    else
                        state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    if (row_reg == dec.n)
                    begin
                        gp_reg[15] <= {7'd0, hit_reg};
                        state_reg  <= S_DONE;
                    end
                    else
                        state_reg <= S_LINE;
                end
                S_LINE:
                begin
                    line_reg  <= mem_q;
                    col_reg   <= 3'd0;
                    px_reg    <= px_base_reg;
                    state_reg <= S_PRD;
                end
                S_PRD: state_reg <= S_PWR;
                S_PWR:
                begin
                    hit_reg  <= hit_reg | (frame_q & line_reg[7]);
                    line_reg <= {line_reg[6:0], 1'b0};
                    col_reg  <= col_reg + 3'd1;
                    if (px_reg == 8'(FRAME_WIDTH - 1))
                        px_reg <= 8'd0;
                    else
                        px_reg <= px_reg + 8'd1;
                    if (col_reg == 3'd7)
                    begin
                        row_reg <= row_reg + 4'd1;
                        if (py_reg == 8'(FRAME_HEIGHT - 1))
                            py_reg <= 8'd0;
                        else
                            py_reg <= py_reg + 8'd1;
                        state_reg <= S_ROW;
                    end
                    else
                        state_reg <= S_PRD;
                end
                S_DONE:
                begin
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
